// ----- rtl/core/edf_pkg.sv -----
// Shared types, codes and constants of the escaped frame deframer.
package edf_pkg;

    localparam int DEFAULT_MAX_FRAME = 256;
    localparam int QUEUE_DEPTH       = 2;

    localparam int BYTE_W   = 8;
    localparam int LENGTH_W = 9;
    localparam int KIND_W   = 3;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_GOOD    = 3'd1,
        KIND_CSUM    = 3'd2,
        KIND_LONG    = 3'd3,
        KIND_ABANDON = 3'd4
    } item_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_CODE      = 3'd0,
        CFG_END_CODE        = 3'd1,
        CFG_ESCAPE_CODE     = 3'd2,
        CFG_ESC_START_CODE  = 3'd3,
        CFG_ESC_END_CODE    = 3'd4,
        CFG_ESC_ESCAPE_CODE = 3'd5
    } cfg_index_t;

    localparam logic [BYTE_W-1:0] RST_START_CODE      = 8'd241;
    localparam logic [BYTE_W-1:0] RST_END_CODE        = 8'd242;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE     = 8'd243;
    localparam logic [BYTE_W-1:0] RST_ESC_START_CODE  = 8'd244;
    localparam logic [BYTE_W-1:0] RST_ESC_END_CODE    = 8'd245;
    localparam logic [BYTE_W-1:0] RST_ESC_ESCAPE_CODE = 8'd246;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] end_code;
        logic [BYTE_W-1:0] escape_code;
        logic [BYTE_W-1:0] esc_start_code;
        logic [BYTE_W-1:0] esc_end_code;
        logic [BYTE_W-1:0] esc_escape_code;
    } edf_cfg_t;

    typedef struct packed {
        item_kind_t          kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [BYTE_W-1:0]   frame_type;
        logic [LENGTH_W-1:0] payload_length;
    } edf_item_t;

endpackage

// ----- rtl/core/edf_front.sv -----
// Front end: unstuffs raw bytes, tracks the frame and classifies each result item.
module edf_front #(
    parameter int MAX_FRAME = edf_pkg::DEFAULT_MAX_FRAME
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  edf_pkg::edf_cfg_t          cfg,
    input  logic                       accept,
    input  logic [edf_pkg::BYTE_W-1:0] rx_byte,
    output logic                       push,
    output edf_pkg::edf_item_t         push_item
);
    import edf_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int LW = (CW > LENGTH_W) ? CW : LENGTH_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME);

    logic              escape_pending_reg, escape_pending_next;
    logic              type_seen_reg, type_seen_next;
    logic [BYTE_W-1:0] type_value_reg, type_value_next;
    logic [CW-1:0]     byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0] running_sum_reg, running_sum_next;
    logic [BYTE_W-1:0] held_byte_reg, held_byte_next;
    logic              draining_reg, draining_next;

    logic [BYTE_W-1:0] decoded;
    logic [LW-1:0]     length_wide;

    always_comb
    begin
        decoded = rx_byte;
        if (escape_pending_reg)
        begin
            if (rx_byte == cfg.esc_escape_code)
                decoded = cfg.escape_code;
            else if (rx_byte == cfg.esc_end_code)
                decoded = cfg.end_code;
            else if (rx_byte == cfg.esc_start_code)
                decoded = cfg.start_code;
        end
    end

    assign length_wide = LW'(byte_count_reg) - LW'(1);

    always_comb
    begin
        escape_pending_next = escape_pending_reg;
        type_seen_next      = type_seen_reg;
        type_value_next     = type_value_reg;
        byte_count_next     = byte_count_reg;
        running_sum_next    = running_sum_reg;
        held_byte_next      = held_byte_reg;
        draining_next       = draining_reg;
        push                = 1'b0;
        push_item.kind           = KIND_PAYLOAD;
        push_item.payload_byte   = '0;
        push_item.frame_type     = type_value_reg;
        push_item.payload_length = '0;

        if (accept)
        begin
            if (draining_reg)
            begin
                // drop everything until the end code
                if (rx_byte == cfg.end_code)
                begin
                    push           = 1'b1;
                    push_item.kind = KIND_LONG;
                    escape_pending_next = 1'b0;
                    type_seen_next      = 1'b0;
                    type_value_next     = '0;
                    byte_count_next     = '0;
                    running_sum_next    = '0;
                    draining_next       = 1'b0;
                end
            end
            else if (rx_byte == cfg.escape_code)
            begin
                escape_pending_next = 1'b1;
            end
            else if (rx_byte == cfg.start_code)
            begin
                push           = type_seen_reg;
                push_item.kind = KIND_ABANDON;
                escape_pending_next = 1'b0;
                type_seen_next      = 1'b0;
                type_value_next     = '0;
                byte_count_next     = '0;
                running_sum_next    = '0;
            end
            else if (rx_byte == cfg.end_code)
            begin
                // empty frames end silently
                push = type_seen_reg && (byte_count_reg != '0);
                if (running_sum_reg != '0)
                begin
                    push_item.kind = KIND_CSUM;
                end
                else
                begin
                    push_item.kind           = KIND_GOOD;
                    push_item.payload_length = length_wide[LENGTH_W-1:0];
                end
                escape_pending_next = 1'b0;
                type_seen_next      = 1'b0;
                type_value_next     = '0;
                byte_count_next     = '0;
                running_sum_next    = '0;
            end
            else
            begin
                escape_pending_next = 1'b0;
                running_sum_next    = running_sum_reg + decoded;
                if (!type_seen_reg)
                begin
                    type_seen_next  = 1'b1;
                    type_value_next = decoded;
                end
                else if (byte_count_reg >= MAX_CNT)
                begin
                    draining_next = 1'b1;
                end
                else
                begin
                    // pass the held byte on; the newest one may be the checksum
                    byte_count_next        = byte_count_reg + 1'b1;
                    held_byte_next         = decoded;
                    push                   = (byte_count_reg != '0);
                    push_item.kind         = KIND_PAYLOAD;
                    push_item.payload_byte = held_byte_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
            type_seen_reg      <= 1'b0;
            type_value_reg     <= '0;
            byte_count_reg     <= '0;
            running_sum_reg    <= '0;
            draining_reg       <= 1'b0;
        end
        else
        begin
            escape_pending_reg <= escape_pending_next;
            type_seen_reg      <= type_seen_next;
            type_value_reg     <= type_value_next;
            byte_count_reg     <= byte_count_next;
            running_sum_reg    <= running_sum_next;
            draining_reg       <= draining_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_byte_reg <= held_byte_next;
    end

`ifndef SYNTHESIS
    a_drain_has_type: assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> type_seen_reg)
        else $error("draining without a frame type");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= MAX_CNT)
        else $error("byte count beyond frame limit");

    a_count_has_type: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_count_reg != '0) |-> type_seen_reg)
        else $error("payload counted before type byte");
`endif

endmodule

// ----- rtl/core/edf_queue.sv -----
// Short queue of classified result items between front and back end.
module edf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  edf_pkg::edf_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output edf_pkg::edf_item_t head_item
);
    import edf_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [NW-1:0] DEPTH_N = NW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);

    edf_item_t     slot_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    assign full       = (count_reg == DEPTH_N);
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");
`endif

endmodule

// ----- rtl/core/edf_back.sv -----
// Back end: output register that presents result items to the receiver.
module edf_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  edf_pkg::edf_item_t           head_item,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [edf_pkg::KIND_W-1:0]   item_kind,
    output logic [edf_pkg::BYTE_W-1:0]   payload_byte,
    output logic [edf_pkg::BYTE_W-1:0]   frame_type,
    output logic [edf_pkg::LENGTH_W-1:0] payload_length
);
    import edf_pkg::*;

    logic      out_valid_reg, out_valid_next;
    edf_item_t item_reg, item_next;

    // load whenever the register is empty or its item is being taken
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        item_next      = pop ? head_item : item_reg;
        out_valid_next = pop || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid      = out_valid_reg;
    assign item_kind      = item_reg.kind;
    assign payload_byte   = item_reg.payload_byte;
    assign frame_type     = item_reg.frame_type;
    assign payload_length = item_reg.payload_length;

`ifndef SYNTHESIS
    a_length_only_good: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (item_reg.kind != KIND_GOOD) |-> item_reg.payload_length == '0)
        else $error("length reported on a non-good item");
`endif

endmodule

// ----- rtl/core/escaped_frame_deframer.sv -----
// Top level of the byte-stuffed frame receiver with additive checksum.
//
// Input channel: rx_byte with in_valid/in_stall, one raw line byte per item.
// Output channel: item_kind, payload_byte, frame_type, payload_length with
// out_valid/out_stall; payload bytes come out one byte late, so the checksum
// byte never appears, and each frame with payload closes with a good, checksum
// error, too long or abandoned status item.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high and a write applies from the next byte on. Indexes above
// the last register are ignored.
// Throughput: one byte per cycle while in_stall is low. The front end classifies a
// byte in the cycle it is accepted and writes its item into a two-entry queue;
// the back end moves the head item into the output register whenever that
// register is empty or its item is being taken.
// Reset clears the frame state, the queue and the output register and loads
// the default codes. While the receiver stalls, the output holds its item,
// the queue keeps filling, and in_stall rises only once the queue is full.
module escaped_frame_deframer #(
    parameter int MAX_FRAME = edf_pkg::DEFAULT_MAX_FRAME
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [edf_pkg::BYTE_W-1:0]    rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [edf_pkg::KIND_W-1:0]    item_kind,
    output logic [edf_pkg::BYTE_W-1:0]    payload_byte,
    output logic [edf_pkg::BYTE_W-1:0]    frame_type,
    output logic [edf_pkg::LENGTH_W-1:0]  payload_length,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [edf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [edf_pkg::BYTE_W-1:0]    cfg_data
);
    import edf_pkg::*;

    edf_cfg_t  cfg_reg, cfg_next;
    logic      accept;
    logic      push;
    edf_item_t push_item;
    logic      full;
    logic      pop;
    logic      head_valid;
    edf_item_t head_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START_CODE:      cfg_next.start_code      = cfg_data;
                CFG_END_CODE:        cfg_next.end_code        = cfg_data;
                CFG_ESCAPE_CODE:     cfg_next.escape_code     = cfg_data;
                CFG_ESC_START_CODE:  cfg_next.esc_start_code  = cfg_data;
                CFG_ESC_END_CODE:    cfg_next.esc_end_code    = cfg_data;
                CFG_ESC_ESCAPE_CODE: cfg_next.esc_escape_code = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code      <= RST_START_CODE;
            cfg_reg.end_code        <= RST_END_CODE;
            cfg_reg.escape_code     <= RST_ESCAPE_CODE;
            cfg_reg.esc_start_code  <= RST_ESC_START_CODE;
            cfg_reg.esc_end_code    <= RST_ESC_END_CODE;
            cfg_reg.esc_escape_code <= RST_ESC_ESCAPE_CODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall = full;
    assign accept   = in_valid && !in_stall;

    edf_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .push      (push),
        .push_item (push_item)
    );

    edf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    edf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_item      (head_item),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .item_kind      (item_kind),
        .payload_byte   (payload_byte),
        .frame_type     (frame_type),
        .payload_length (payload_length)
    );

endmodule
